// File: hdl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, operation codes and status codes of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DataW        = 32;
  localparam int PosW         = 7;
  localparam int DefaultDepth = 64;

  typedef enum logic [2:0] {
    OpAppend    = 3'd0,
    OpPrepend   = 3'd1,
    OpPop       = 3'd2,
    OpRemovePos = 3'd3,
    OpRemoveVal = 3'd4,
    OpFind      = 3'd5,
    OpRead      = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatEmpty    = 3'd1,
    StatRange    = 3'd2,
    StatNotFound = 3'd3,
    StatFull     = 3'd4
  } status_e;

endpackage

// File: hdl/ole_store.sv
// ----------------------------------------------------------------------------
// ole_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ole_store #(
  parameter int DEPTH = ole_pkg::DefaultDepth,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ole_pkg::DataW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [ole_pkg::DataW-1:0] rdata_o
);

  logic [ole_pkg::DataW-1:0] mem [DEPTH];
  logic [ole_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Append, errors, the unused code and a prepend to an empty list need no walk;
// a read waits on the registered memory read; prepend, pop and removal shift
// the entries behind them, and a find or removal by value scans from the head.
// The next request is accepted in the done cycle; results cannot stall.
// Reset empties the list at once; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int DEPTH = ole_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       op_i,
  input  logic signed [ole_pkg::DataW-1:0] value_i,
  input  logic [ole_pkg::PosW-1:0]         position_i,
  output logic                             done_o,
  output logic signed [ole_pkg::DataW-1:0] data_o,
  output logic [ole_pkg::PosW-1:0]         found_position_o,
  output logic [2:0]                       status_o,
  output logic [ole_pkg::PosW-1:0]         count_o,
  output logic                             is_empty_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = ole_pkg::PosW;
  localparam int DW   = ole_pkg::DataW;
  localparam int CmpW = (CW > PW) ? CW : PW;
  localparam logic [CmpW-1:0] DepthExt = CmpW'(DEPTH);

  typedef enum logic [5:0] {
    Idle      = 6'b000001,
    ShiftUp   = 6'b000010,
    WriteHead = 6'b000100,
    ShiftDown = 6'b001000,
    Search    = 6'b010000,
    ReadWait  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_go_q, rd_go_d;
  logic          pend_vld_q;
  logic [CW-1:0] pend_idx_q;
  logic [CW-1:0] k_q, k_d;
  logic [PW-1:0] fpos_q, fpos_d;
  ole_pkg::op_e  op_q;
  logic [DW-1:0] val_q;
  logic [DW-1:0] hold_q;
  logic          done_q;
  logic [DW-1:0] res_data_q;
  logic [PW-1:0] res_fpos_q;
  logic [2:0]    res_status_q;
  logic [PW-1:0] res_count_q;
  logic          res_empty_q;

  logic          accept;
  ole_pkg::op_e  op_in;
  logic [CmpW-1:0] pos_ext, pos_m1, cnt_ext, hit_ext, cnt_d_ext;
  logic          pos_bad, is_full, is_zero;
  logic [CW-1:0] last_idx;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic          fin;
  logic [DW-1:0] fin_data;
  logic [PW-1:0] fin_fpos;
  ole_pkg::status_e fin_status;

  assign busy     = (state_q != Idle);
  assign accept   = start && !busy;
  assign op_in    = ole_pkg::op_e'(op_i);
  assign pos_ext  = CmpW'(position_i);
  assign pos_m1   = pos_ext - CmpW'(1);
  assign cnt_ext  = CmpW'(count_q);
  assign hit_ext  = CmpW'(pend_idx_q) + CmpW'(1);
  assign cnt_d_ext = CmpW'(count_d);
  assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_zero  = (count_q == '0);
  assign last_idx = count_q - CW'(1);

  ole_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    rd_go_d    = rd_go_q;
    k_d        = k_q;
    fpos_d     = fpos_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = rd_idx_q[AW-1:0];
    fin        = 1'b0;
    fin_data   = '0;
    fin_fpos   = '0;
    fin_status = ole_pkg::StatOk;

    unique case (state_q)
      Idle: begin
        rd_go_d = 1'b0;
        if (accept) begin
          unique case (op_in)
            ole_pkg::OpAppend: begin
              fin = 1'b1;
              if (is_full) begin
                fin_status = ole_pkg::StatFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = value_i;
                count_d   = count_q + CW'(1);
              end
            end
            ole_pkg::OpPrepend: begin
              if (is_full) begin
                fin        = 1'b1;
                fin_status = ole_pkg::StatFull;
              end else if (is_zero) begin
                fin       = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = value_i;
                count_d   = CW'(1);
              end else begin
                rd_idx_d = last_idx;
                rd_go_d  = 1'b1;
                state_d  = ShiftUp;
              end
            end
            ole_pkg::OpPop: begin
              if (is_zero) begin
                fin        = 1'b1;
                fin_status = ole_pkg::StatEmpty;
              end else begin
                k_d      = '0;
                rd_idx_d = '0;
                rd_go_d  = 1'b1;
                fpos_d   = PW'(1);
                state_d  = ShiftDown;
              end
            end
            ole_pkg::OpRemovePos: begin
              if (pos_bad) begin
                fin        = 1'b1;
                fin_status = ole_pkg::StatRange;
              end else begin
                k_d      = pos_m1[CW-1:0];
                rd_idx_d = pos_m1[CW-1:0];
                rd_go_d  = 1'b1;
                fpos_d   = position_i;
                state_d  = ShiftDown;
              end
            end
            ole_pkg::OpRemoveVal, ole_pkg::OpFind: begin
              if (is_zero) begin
                fin        = 1'b1;
                fin_status = ole_pkg::StatEmpty;
              end else begin
                rd_idx_d = '0;
                rd_go_d  = 1'b1;
                state_d  = Search;
              end
            end
            ole_pkg::OpRead: begin
              if (is_zero) begin
                fin        = 1'b1;
                fin_status = ole_pkg::StatEmpty;
              end else if (pos_bad) begin
                fin        = 1'b1;
                fin_status = ole_pkg::StatRange;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_m1[AW-1:0];
                state_d   = ReadWait;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ShiftUp: begin
        ram_re = rd_go_q;
        if (rd_go_q) begin
          if (rd_idx_q == '0) begin
            rd_go_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q - CW'(1);
          end
        end
        if (pend_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q[AW-1:0] + AW'(1);
          if (pend_idx_q == '0) begin
            state_d = WriteHead;
          end
        end
      end
      WriteHead: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        fin       = 1'b1;
      end
      ShiftDown: begin
        ram_re = rd_go_q;
        if (rd_go_q) begin
          if (rd_idx_q == last_idx) begin
            rd_go_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + CW'(1);
          end
        end
        if (pend_vld_q) begin
          if (pend_idx_q != k_q) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_q[AW-1:0] - AW'(1);
          end
          if (pend_idx_q == last_idx) begin
            fin      = 1'b1;
            count_d  = last_idx;
            fin_fpos = fpos_q;
            if (op_q == ole_pkg::OpPop) begin
              fin_data = (pend_idx_q == k_q) ? ram_rdata : hold_q;
            end
          end
        end
      end
      Search: begin
        ram_re = rd_go_q;
        if (rd_go_q) begin
          if (rd_idx_q == last_idx) begin
            rd_go_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + CW'(1);
          end
        end
        if (pend_vld_q) begin
          if (ram_rdata == val_q) begin
            if (op_q == ole_pkg::OpFind) begin
              fin      = 1'b1;
              fin_fpos = hit_ext[PW-1:0];
            end else begin
              ram_re   = 1'b0;
              k_d      = pend_idx_q;
              rd_idx_d = pend_idx_q;
              rd_go_d  = 1'b1;
              fpos_d   = hit_ext[PW-1:0];
              state_d  = ShiftDown;
            end
          end else if (pend_idx_q == last_idx) begin
            fin        = 1'b1;
            fin_status = ole_pkg::StatNotFound;
          end
        end
      end
      ReadWait: begin
        fin      = 1'b1;
        fin_data = ram_rdata;
      end
      default: begin
        state_d = Idle;
      end
    endcase

    if (fin) begin
      state_d = Idle;
      rd_go_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Idle;
      count_q    <= '0;
      rd_go_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_go_q    <= rd_go_d;
      pend_vld_q <= ram_re && (state_q != Idle);
      done_q     <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    pend_idx_q <= rd_idx_q;
    k_q        <= k_d;
    fpos_q     <= fpos_d;
    if (accept) begin
      op_q  <= op_in;
      val_q <= value_i;
    end
    if (pend_vld_q && (pend_idx_q == k_q)) begin
      hold_q <= ram_rdata;
    end
    if (fin) begin
      res_data_q   <= fin_data;
      res_fpos_q   <= fin_fpos;
      res_status_q <= fin_status;
      res_count_q  <= cnt_d_ext[PW-1:0];
      res_empty_q  <= (count_d == '0);
    end
  end

  assign done_o           = done_q;
  assign data_o           = res_data_q;
  assign found_position_o = res_fpos_q;
  assign status_o         = res_status_q;
  assign count_o          = res_count_q;
  assign is_empty_o       = res_empty_q;

  // An accepted request either makes the engine busy or reports on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted request produced neither work nor a result");

  // A full status is only reported when the list holds every entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ole_pkg::StatFull)) |-> (count_o == DepthExt[PW-1:0]))
    else $error("full status reported on a list that is not full");

  // Writes never land beyond the first free entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= count_q))
    else $error("entry write beyond the end of the list");

  // An empty status always comes with an empty list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ole_pkg::StatEmpty)) |-> is_empty_o)
    else $error("empty status reported on a list that holds entries");

endmodule

// File: tb/ordered_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Drives list requests with random gaps; checks typed directed rows against
// their table entry and all other results against a shadow copy of the list.
// A directed table covers empty, range, not-found, duplicate and extreme-value
// cases. Random phases follow: fill to full, drain to empty, and mixed traffic.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;

  localparam int Depth        = ole_pkg::DefaultDepth;
  localparam int DataW        = ole_pkg::DataW;
  localparam int PosW         = ole_pkg::PosW;
  localparam int RandomItems  = 700;
  localparam int CycleLimit   = 1_000_000;
  localparam int NumDirected  = 24;
  localparam int ReportLimit  = 10;
  localparam logic [2:0] OpUnused = 3'd7;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic [PosW-1:0]         position;
    ole_pkg::status_e        status;
    logic [PosW-1:0]         count;
    logic                    is_empty;
  } list_result_t;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
    logic                    typed;
    list_result_t            want;
  } stim_row_t;

  typedef enum logic [1:0] {
    PhaseFill,
    PhaseDrain,
    PhaseMix
  } stim_phase_e;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start      = 1'b0;
  logic [2:0]              op_i       = ole_pkg::OpAppend;
  logic signed [DataW-1:0] value_i    = '0;
  logic [PosW-1:0]         position_i = '0;
  logic                    busy;
  logic                    done_o;
  logic signed [DataW-1:0] data_o;
  logic [PosW-1:0]         found_position_o;
  logic [2:0]              status_o;
  logic [PosW-1:0]         count_o;
  logic                    is_empty_o;

  logic signed [DataW-1:0] shadow_list [Depth];
  int                      shadow_count = 0;
  list_result_t            pending_results [$];
  int                      mismatch_count = 0;
  int                      cycle_count = 0;

  stim_row_t directed_rows [NumDirected] = '{
    '{ole_pkg::OpPop, 32'sd0, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatEmpty, 7'd0, 1'b1}},
    '{ole_pkg::OpRead, 32'sd0, 7'd1, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatEmpty, 7'd0, 1'b1}},
    '{ole_pkg::OpRemovePos, 32'sd0, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatRange, 7'd0, 1'b1}},
    '{ole_pkg::OpRemovePos, 32'sd0, 7'd64, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatRange, 7'd0, 1'b1}},
    '{ole_pkg::OpRemoveVal, 32'sd0, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatEmpty, 7'd0, 1'b1}},
    '{ole_pkg::OpFind, -32'sd1, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatEmpty, 7'd0, 1'b1}},
    '{OpUnused, -32'sd1, 7'd127, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatOk, 7'd0, 1'b1}},
    '{ole_pkg::OpAppend, 32'sh7FFF_FFFF, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatOk, 7'd1, 1'b0}},
    '{ole_pkg::OpPrepend, 32'sh8000_0000, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatOk, 7'd2, 1'b0}},
    '{ole_pkg::OpAppend, -32'sd1, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatOk, 7'd3, 1'b0}},
    '{ole_pkg::OpAppend, 32'sd0, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatOk, 7'd4, 1'b0}},
    '{ole_pkg::OpPrepend, -32'sd1, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatOk, 7'd5, 1'b0}},
    '{ole_pkg::OpRead, 32'sd0, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatRange, 7'd5, 1'b0}},
    '{ole_pkg::OpRead, 32'sd0, 7'd6, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatRange, 7'd5, 1'b0}},
    '{ole_pkg::OpRead, 32'sd0, 7'd127, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatRange, 7'd5, 1'b0}},
    '{ole_pkg::OpRead, 32'sd0, 7'd2, 1'b0, '0},
    '{ole_pkg::OpFind, -32'sd1, 7'd0, 1'b0, '0},
    '{ole_pkg::OpFind, 32'sd12345, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatNotFound, 7'd5, 1'b0}},
    '{ole_pkg::OpRemoveVal, 32'sh5A5A_5A5A, 7'd0, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatNotFound, 7'd5, 1'b0}},
    '{ole_pkg::OpRemoveVal, -32'sd1, 7'd0, 1'b0, '0},
    '{ole_pkg::OpRemovePos, 32'sd0, 7'd4, 1'b0, '0},
    '{ole_pkg::OpRemovePos, 32'sd0, 7'd127, 1'b1,
      '{32'sd0, 7'd0, ole_pkg::StatRange, 7'd3, 1'b0}},
    '{ole_pkg::OpPop, 32'sd0, 7'd0, 1'b0, '0},
    '{OpUnused, 32'sd77, 7'd1, 1'b0, '0}
  };

  ordered_list_engine #(
    .DEPTH(Depth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .data_o          (data_o),
    .found_position_o(found_position_o),
    .status_o        (status_o),
    .count_o         (count_o),
    .is_empty_o      (is_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void drop_entry(input int idx);
    for (int i = idx; i + 1 < shadow_count; i++) begin
      shadow_list[i] = shadow_list[i + 1];
    end
    shadow_count--;
  endfunction

  function automatic list_result_t apply_request(input logic [2:0] op,
                                                 input logic signed [DataW-1:0] value,
                                                 input logic [PosW-1:0] pos);
    list_result_t res;
    int           hit;
    res = '0;
    hit = 0;
    case (op)
      ole_pkg::OpAppend, ole_pkg::OpPrepend: begin
        if (shadow_count >= Depth) begin
          res.status = ole_pkg::StatFull;
        end else if (op == ole_pkg::OpAppend) begin
          shadow_list[shadow_count] = value;
          shadow_count++;
        end else begin
          for (int i = shadow_count; i > 0; i--) begin
            shadow_list[i] = shadow_list[i - 1];
          end
          shadow_list[0] = value;
          shadow_count++;
        end
      end
      ole_pkg::OpPop: begin
        if (shadow_count == 0) begin
          res.status = ole_pkg::StatEmpty;
        end else begin
          res.data     = shadow_list[0];
          res.position = PosW'(1);
          drop_entry(0);
        end
      end
      ole_pkg::OpRemovePos: begin
        if (pos == 0 || int'(pos) > shadow_count) begin
          res.status = ole_pkg::StatRange;
        end else begin
          res.position = pos;
          drop_entry(int'(pos) - 1);
        end
      end
      ole_pkg::OpRemoveVal, ole_pkg::OpFind: begin
        if (shadow_count == 0) begin
          res.status = ole_pkg::StatEmpty;
        end else begin
          for (int i = 0; i < shadow_count && hit == 0; i++) begin
            if (shadow_list[i] == value) hit = i + 1;
          end
          res.position = PosW'(hit);
          if (hit == 0) begin
            res.status = ole_pkg::StatNotFound;
          end else if (op == ole_pkg::OpRemoveVal) begin
            drop_entry(hit - 1);
          end
        end
      end
      ole_pkg::OpRead: begin
        if (shadow_count == 0) begin
          res.status = ole_pkg::StatEmpty;
        end else if (pos == 0 || int'(pos) > shadow_count) begin
          res.status = ole_pkg::StatRange;
        end else begin
          res.data = shadow_list[int'(pos) - 1];
        end
      end
      default: begin
      end
    endcase
    res.count    = PosW'(shadow_count);
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic issue_request(input logic [2:0] op,
                               input logic signed [DataW-1:0] value,
                               input logic [PosW-1:0] pos, input logic typed,
                               input list_result_t want);
    list_result_t predicted;
    start      <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    predicted = apply_request(op, value, pos);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_between_requests();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(40, 160);
    if (gap > 0) begin
      start      <= 1'b0;
      op_i       <= 3'($urandom());
      value_i    <= $urandom();
      position_i <= PosW'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < ReportLimit) begin
          $display("unexpected result: data %0d pos %0d status %0d count %0d empty %0b",
                   data_o, found_position_o, status_o, count_o, is_empty_o);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (data_o !== want.data || found_position_o !== want.position ||
            status_o !== want.status || count_o !== want.count ||
            is_empty_o !== want.is_empty) begin
          if (mismatch_count < ReportLimit) begin
            $display("mismatch: expected data %0d pos %0d status %0d count %0d empty %0b",
                     want.data, want.position, want.status, want.count, want.is_empty);
            $display("          actual   data %0d pos %0d status %0d count %0d empty %0b",
                     data_o, found_position_o, status_o, count_o, is_empty_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("ordered_list_engine_tb failed");
    $finish;
  end

  initial begin
    stim_phase_e             phase;
    int                      mix_left;
    int                      roll;
    int                      insert_pct;
    int                      dup_pct;
    logic [2:0]              op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
    phase    = PhaseFill;
    mix_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                    directed_rows[i].typed, directed_rows[i].want);
      idle_between_requests();
    end

    for (int n = 0; n < RandomItems; n++) begin
      case (phase)
        PhaseFill: begin
          if (shadow_count == Depth && $urandom_range(0, 7) == 0) phase = PhaseDrain;
        end
        PhaseDrain: begin
          if (shadow_count == 0 && $urandom_range(0, 3) == 0) begin
            phase    = PhaseMix;
            mix_left = 60;
          end
        end
        default: begin
          if (mix_left == 0) phase = PhaseFill;
          else mix_left--;
        end
      endcase
      insert_pct = (phase == PhaseFill) ? 75 : (phase == PhaseDrain) ? 10 : 35;

      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        op = $urandom_range(0, 1) ? ole_pkg::OpAppend : ole_pkg::OpPrepend;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 20) op = ole_pkg::OpPop;
        else if (roll < 40) op = ole_pkg::OpRemovePos;
        else if (roll < 60) op = ole_pkg::OpRemoveVal;
        else if (roll < 78) op = ole_pkg::OpFind;
        else if (roll < 97) op = ole_pkg::OpRead;
        else op = OpUnused;
      end

      dup_pct = (op == ole_pkg::OpAppend || op == ole_pkg::OpPrepend) ? 20 : 65;
      roll = $urandom_range(0, 99);
      if (shadow_count > 0 && roll < dup_pct) begin
        value = shadow_list[$urandom_range(0, shadow_count - 1)];
      end else if (roll < 88) begin
        value = $urandom();
      end else begin
        case ($urandom_range(0, 3))
          0: value = 32'sh7FFF_FFFF;
          1: value = 32'sh8000_0000;
          2: value = -32'sd1;
          default: value = 32'sd0;
        endcase
      end

      roll = $urandom_range(0, 99);
      if (shadow_count > 0 && roll < 75) pos = PosW'($urandom_range(1, shadow_count));
      else if (roll < 85) pos = '0;
      else if (roll < 95) pos = PosW'(shadow_count + 1);
      else pos = PosW'($urandom_range(0, 127));

      issue_request(op, value, pos, 1'b0, '0);
      if (n + 1 < RandomItems) idle_between_requests();
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("ordered_list_engine_tb passed");
    end else begin
      $display("ordered_list_engine_tb failed");
    end
    $finish;
  end

endmodule
